/* hw/rtl/bgu_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constant tables of the bilinear grid upsampler.
package bgu_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int FINE_W    = 10;
  localparam int CNT_W     = 7;
  localparam int FAC_W     = 5;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // floor(2^RECIP_SHIFT / f) gives a quotient that is exact or one low
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = FINE_W + RECIP_W;
  localparam int REM_W       = FAC_W + 1;
  localparam int LIM_W       = CNT_W + FAC_W;

  localparam int WGT_W   = 2 * FAC_W;
  localparam int TERM_W  = WGT_W + SAMPLE_BITS;
  localparam int QUO_W   = SAMPLE_BITS + FRAC_BITS;
  localparam int DIVD_W  = TERM_W + FRAC_BITS + 1;
  localparam int DVSR_W  = WGT_W + 1;
  localparam int OUT_W   = 24;

  localparam int BANK_AW    = ROW_W + COL_W - 2;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS  = 4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT  = 2'd0,
    REG_COL_COUNT  = 2'd1,
    REG_ROW_FACTOR = 2'd2,
    REG_COL_FACTOR = 2'd3
  } reg_idx_t;

  localparam logic [RECIP_W-1:0] RECIP [32] = '{
    17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
    17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
    17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
    17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114
  };

  typedef struct packed {
    logic [CNT_W-1:0] nr;
    logic [CNT_W-1:0] nc;
    logic [FAC_W-1:0] fr;
    logic [FAC_W-1:0] fc;
  } cfg_t;

  typedef struct packed {
    logic                   query;
    logic [ROW_W-1:0]       raw_row;
    logic [COL_W-1:0]       raw_col;
    logic [SAMPLE_BITS-1:0] sample;
    logic [FINE_W-1:0]      fine_row;
    logic [FINE_W-1:0]      fine_col;
  } item_t;

  typedef struct packed {
    logic                   query;
    logic                   oor;
    logic [ROW_W-1:0]       y;
    logic [FAC_W-1:0]       t;
    logic [COL_W-1:0]       x;
    logic [FAC_W-1:0]       u;
    logic [ROW_W-1:0]       raw_row;
    logic [COL_W-1:0]       raw_col;
    logic [SAMPLE_BITS-1:0] sample;
  } loc_t;

  typedef struct packed {
    logic             oor;
    logic             ypar;
    logic             xpar;
    logic [WGT_W-1:0] w00;
    logic [WGT_W-1:0] w01;
    logic [WGT_W-1:0] w10;
    logic [WGT_W-1:0] w11;
    logic [WGT_W-1:0] den;
  } wgt_t;

  typedef struct packed {
    logic              oor;
    logic [DIVD_W-1:0] dividend;
    logic [DVSR_W-1:0] divisor;
  } div_t;

endpackage

/* hw/rtl/bgu_locate.sv */
`timescale 1ns / 1ps
// Three-stage cell locator: divides fine indexes by the factors and clamps the last cell.
module bgu_locate import bgu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output loc_t  out_loc
);

  typedef struct packed {
    item_t             item;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_c;
  } s1_t;

  typedef struct packed {
    item_t             item;
    logic              oor;
    logic [FINE_W-1:0] q_r;
    logic [FINE_W-1:0] q_c;
    logic [REM_W-1:0]  r_r;
    logic [REM_W-1:0]  r_c;
  } s2_t;

  logic v1, v2;
  logic rdy1, rdy2, rdy3;
  s1_t  s1;
  s2_t  s2;
  s2_t  s2_next;
  loc_t loc_next;

  logic [FINE_W-1:0]       q0_r, q0_c, q_r, q_c;
  logic [FINE_W+FAC_W-1:0] back_r, back_c, diff_r, diff_c;
  logic [LIM_W-1:0]        lim_r, lim_c;
  logic [REM_W-1:0]        r_r, r_c;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 2: quotient estimate and its remainder, range check
  always_comb begin
    q0_r   = s1.prod_r[RECIP_SHIFT +: FINE_W];
    q0_c   = s1.prod_c[RECIP_SHIFT +: FINE_W];
    back_r = (FINE_W+FAC_W)'(q0_r) * (FINE_W+FAC_W)'(cfg.fr);
    back_c = (FINE_W+FAC_W)'(q0_c) * (FINE_W+FAC_W)'(cfg.fc);
    diff_r = (FINE_W+FAC_W)'(s1.item.fine_row) - back_r;
    diff_c = (FINE_W+FAC_W)'(s1.item.fine_col) - back_c;
    lim_r  = LIM_W'(cfg.nr - CNT_W'(1)) * LIM_W'(cfg.fr) + LIM_W'(1);
    lim_c  = LIM_W'(cfg.nc - CNT_W'(1)) * LIM_W'(cfg.fc) + LIM_W'(1);
    s2_next.item = s1.item;
    s2_next.oor  = (LIM_W'(s1.item.fine_row) >= lim_r) ||
                   (LIM_W'(s1.item.fine_col) >= lim_c);
    s2_next.q_r  = q0_r;
    s2_next.q_c  = q0_c;
    s2_next.r_r  = diff_r[REM_W-1:0];
    s2_next.r_c  = diff_c[REM_W-1:0];
  end

  // stage 3: correct the estimate, step back on the last row or column
  always_comb begin
    q_r = s2.q_r;
    r_r = s2.r_r;
    if (s2.r_r >= REM_W'(cfg.fr)) begin
      q_r = s2.q_r + FINE_W'(1);
      r_r = s2.r_r - REM_W'(cfg.fr);
    end
    q_c = s2.q_c;
    r_c = s2.r_c;
    if (s2.r_c >= REM_W'(cfg.fc)) begin
      q_c = s2.q_c + FINE_W'(1);
      r_c = s2.r_c - REM_W'(cfg.fc);
    end
    loc_next.query   = s2.item.query;
    loc_next.oor     = s2.oor;
    loc_next.raw_row = s2.item.raw_row;
    loc_next.raw_col = s2.item.raw_col;
    loc_next.sample  = s2.item.sample;
    if (cfg.nr > CNT_W'(1) && q_r >= FINE_W'(cfg.nr - CNT_W'(1))) begin
      loc_next.y = ROW_W'(cfg.nr - CNT_W'(2));
      loc_next.t = cfg.fr;
    end else begin
      loc_next.y = q_r[ROW_W-1:0];
      loc_next.t = r_r[FAC_W-1:0];
    end
    if (q_c >= FINE_W'(cfg.nc - CNT_W'(1))) begin
      loc_next.x = COL_W'(cfg.nc - CNT_W'(2));
      loc_next.u = cfg.fc;
    end else begin
      loc_next.x = q_c[COL_W-1:0];
      loc_next.u = r_c[FAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1.item   <= in_item;
      s1.prod_r <= PROD_W'(in_item.fine_row) * PROD_W'(RECIP[cfg.fr]);
      s1.prod_c <= PROD_W'(in_item.fine_col) * PROD_W'(RECIP[cfg.fc]);
    end
    if (rdy2 && v1) s2 <= s2_next;
    if (rdy3 && v2) out_loc <= loc_next;
  end

endmodule

/* hw/rtl/bgu_store.sv */
`timescale 1ns / 1ps
// Coarse sample store in four parity banks, plus the blend weight stage.
module bgu_store import bgu_pkg::*; (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cfg_t                                   cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  loc_t                                   in_loc,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output wgt_t                                   out_wgt,
  output logic [NUM_BANKS-1:0][SAMPLE_BITS-1:0]  out_data
);

  logic             rdy;
  logic             take;
  logic [FAC_W-1:0] a_r, a_c;
  logic [BANK_AW-1:0] wr_addr;

  assign rdy      = !out_valid || out_ready;
  assign in_ready = rdy;
  assign take     = rdy && in_valid;
  assign wr_addr  = {in_loc.raw_row[ROW_W-1:1], in_loc.raw_col[COL_W-1:1]};

  // bank {py,px} holds the samples whose row and column parities are py and px
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic PY = 1'(b / 2);
    localparam logic PX = 1'(b % 2);
    logic [SAMPLE_BITS-1:0] mem [BANK_DEPTH];
    logic [ROW_W-1:0]       row_sel;
    logic [COL_W-1:0]       col_sel;
    logic [BANK_AW-1:0]     rd_addr;
    logic                   we;

    assign row_sel = (in_loc.y[0] == PY) ? in_loc.y : in_loc.y + ROW_W'(1);
    assign col_sel = (in_loc.x[0] == PX) ? in_loc.x : in_loc.x + COL_W'(1);
    assign rd_addr = {row_sel[ROW_W-1:1], col_sel[COL_W-1:1]};
    assign we      = take && (in_loc.query == CMD_LOAD) &&
                     (in_loc.raw_row[0] == PY) && (in_loc.raw_col[0] == PX);

    always_ff @(posedge clk) begin
      if (we) mem[wr_addr] <= in_loc.sample;
      if (take && in_loc.query == CMD_QUERY) out_data[b] <= mem[rd_addr];
    end
  end

  assign a_r = cfg.fr - in_loc.t;
  assign a_c = cfg.fc - in_loc.u;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy) begin
      // loads end here
      out_valid <= in_valid && (in_loc.query == CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_wgt.oor  <= in_loc.oor;
      out_wgt.ypar <= in_loc.y[0];
      out_wgt.xpar <= in_loc.x[0];
      out_wgt.w00  <= WGT_W'(a_r) * WGT_W'(a_c);
      out_wgt.w01  <= WGT_W'(a_r) * WGT_W'(in_loc.u);
      out_wgt.w10  <= WGT_W'(in_loc.t) * WGT_W'(a_c);
      out_wgt.w11  <= WGT_W'(in_loc.t) * WGT_W'(in_loc.u);
      out_wgt.den  <= WGT_W'(cfg.fr) * WGT_W'(cfg.fc);
    end
  end

endmodule

/* hw/rtl/bgu_blend.sv */
`timescale 1ns / 1ps
// Two-stage blend: weighted corner products, then the sum and rounding offset.
module bgu_blend import bgu_pkg::*; (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  wgt_t                                  in_wgt,
  input  logic [NUM_BANKS-1:0][SAMPLE_BITS-1:0] in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output div_t                                  out_div
);

  typedef struct packed {
    logic              oor;
    logic [WGT_W-1:0]  den;
    logic [TERM_W-1:0] p00;
    logic [TERM_W-1:0] p01;
    logic [TERM_W-1:0] p10;
    logic [TERM_W-1:0] p11;
  } prod_t;

  logic  v1;
  logic  rdy1, rdy2;
  prod_t s1;
  logic [SAMPLE_BITS-1:0] g00, g01, g10, g11;
  logic [TERM_W-1:0]      num;

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // drop corners with zero weight; a one-row grid never loads the row below
  assign g00 = (in_wgt.w00 == '0) ? '0 : in_data[{in_wgt.ypar, in_wgt.xpar}];
  assign g01 = (in_wgt.w01 == '0) ? '0 : in_data[{in_wgt.ypar, ~in_wgt.xpar}];
  assign g10 = (in_wgt.w10 == '0) ? '0 : in_data[{~in_wgt.ypar, in_wgt.xpar}];
  assign g11 = (in_wgt.w11 == '0) ? '0 : in_data[{~in_wgt.ypar, ~in_wgt.xpar}];

  // the weights sum to den, so the sum never outgrows TERM_W
  always_comb begin
    num = s1.p00 + s1.p01 + s1.p10 + s1.p11;
    if (s1.oor) num = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1.oor <= in_wgt.oor;
      s1.den <= in_wgt.den;
      s1.p00 <= TERM_W'(in_wgt.w00) * TERM_W'(g00);
      s1.p01 <= TERM_W'(in_wgt.w01) * TERM_W'(g01);
      s1.p10 <= TERM_W'(in_wgt.w10) * TERM_W'(g10);
      s1.p11 <= TERM_W'(in_wgt.w11) * TERM_W'(g11);
    end
    if (rdy2 && v1) begin
      // round to nearest: (2*num*2^F + den) / (2*den)
      out_div.oor      <= s1.oor;
      out_div.dividend <= {num, (FRAC_BITS+1)'(0)} + DIVD_W'(s1.den);
      out_div.divisor  <= {s1.den, 1'b0};
    end
  end

endmodule

/* hw/rtl/bgu_divider.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, a few quotient bits per stage.
module bgu_divider import bgu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  div_t             in_div,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [QUO_W-1:0] quotient,
  output logic             oor
);

  localparam int STEP = 4;
  localparam int NSTG = (QUO_W + STEP - 1) / STEP;

  logic              v    [NSTG];
  logic              rdy  [NSTG];
  logic [DVSR_W-1:0] rem  [NSTG];
  logic [QUO_W-1:0]  lq   [NSTG];
  logic [DVSR_W-1:0] dv   [NSTG];
  logic              flag [NSTG];

  // lq holds the unused dividend bits on top and the quotient bits below
  function automatic logic [DVSR_W+QUO_W-1:0] div_steps(
    input logic [DVSR_W-1:0] r_in,
    input logic [QUO_W-1:0]  q_in,
    input logic [DVSR_W-1:0] d,
    input int                n
  );
    logic [DVSR_W:0]   trial;
    logic [DVSR_W-1:0] r;
    logic [QUO_W-1:0]  q;
    r = r_in;
    q = q_in;
    for (int i = 0; i < STEP; i++) begin
      if (i < n) begin
        trial = {r, q[QUO_W-1]};
        q     = {q[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
          trial = trial - {1'b0, d};
          q[0]  = 1'b1;
        end
        r = trial[DVSR_W-1:0];
      end
    end
    return {r, q};
  endfunction

  always_comb begin
    rdy[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) rdy[k] = !v[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NSTG-1];
  assign quotient  = lq[NSTG-1];
  assign oor       = flag[NSTG-1];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int NB = (QUO_W - k * STEP < STEP) ? QUO_W - k * STEP : STEP;
    logic              vin;
    logic              fin;
    logic [DVSR_W-1:0] rin;
    logic [DVSR_W-1:0] din;
    logic [QUO_W-1:0]  qin;

    if (k == 0) begin : g_head
      // the top bits of the dividend already sit below the divisor
      assign vin = in_valid;
      assign fin = in_div.oor;
      assign rin = in_div.dividend[DIVD_W-1:QUO_W];
      assign qin = in_div.dividend[QUO_W-1:0];
      assign din = in_div.divisor;
    end else begin : g_body
      assign vin = v[k-1];
      assign fin = flag[k-1];
      assign rin = rem[k-1];
      assign qin = lq[k-1];
      assign din = dv[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin) begin
        {rem[k], lq[k]} <= div_steps(rin, qin, din, NB);
        dv[k]           <= din;
        flag[k]         <= fin;
      end
    end
  end

endmodule

/* hw/rtl/bilinear_grid_upsampler.sv */
`timescale 1ns / 1ps
// Bilinear grid upsampler: coarse sample store and fine-grid query pipeline.
//
// Input channel (in_valid/in_ready) carries commands. A load writes sample into
// the coarse store at (raw_row, raw_col) and gives no result. A query names the
// fine point (fine_row, fine_col) and gives one result on the output channel
// (out_valid/out_ready): interp_value with 8 fraction bits, rounded to nearest,
// or 0 with out_of_range set when the point is off the fine grid.
// Configuration registers are written through cfg_write/cfg_index/cfg_data; the
// user must write them only while no query is in flight; the block does not
// enforce it. Store entries read before being loaded are undefined. Throughput: one
// command per cycle while the output is not stalled. Pipeline: 12 register stages
// (3 locate, 1 store read, 2 blend, 6 divider stages retiring 4 quotient bits each).
// Loads write the store in order with queries, so a query sees every earlier load.
// Each stage holds only while full and blocked, so a stalled receiver fills the
// pipeline before in_ready drops; bubbles are squeezed out.
// Reset clears the pipeline and sets all four registers to 2; it does not clear
// the store.
module bilinear_grid_upsampler import bgu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic [ROW_W-1:0]       raw_row,
  input  logic [COL_W-1:0]       raw_col,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [FINE_W-1:0]      fine_row,
  input  logic [FINE_W-1:0]      fine_col,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       interp_value,
  output logic                   out_of_range
);

  localparam logic [OUT_W-1:0] VALUE_MAX = OUT_W'(((1 << SAMPLE_BITS) - 1) << FRAC_BITS);

  logic [CNT_W-1:0] row_count, col_count;
  logic [FAC_W-1:0] row_factor, col_factor;
  cfg_t  cfg;
  item_t in_item;

  logic loc_valid, loc_ready;
  loc_t loc;
  logic wgt_valid, wgt_ready;
  wgt_t wgt;
  logic [NUM_BANKS-1:0][SAMPLE_BITS-1:0] bank_data;
  logic div_valid, div_ready;
  div_t div_in;
  logic [QUO_W-1:0] quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= CNT_W'(2);
      col_count  <= CNT_W'(2);
      row_factor <= FAC_W'(2);
      col_factor <= FAC_W'(2);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW_COUNT:  row_count  <= cfg_data[CNT_W-1:0];
        REG_COL_COUNT:  col_count  <= cfg_data[CNT_W-1:0];
        REG_ROW_FACTOR: row_factor <= cfg_data[FAC_W-1:0];
        REG_COL_FACTOR: col_factor <= cfg_data[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to the usable range
  always_comb begin
    if (row_count == CNT_W'(0))            cfg.nr = CNT_W'(1);
    else if (row_count > CNT_W'(MAX_ROWS)) cfg.nr = CNT_W'(MAX_ROWS);
    else                                   cfg.nr = row_count;
    if (col_count < CNT_W'(2))             cfg.nc = CNT_W'(2);
    else if (col_count > CNT_W'(MAX_COLS)) cfg.nc = CNT_W'(MAX_COLS);
    else                                   cfg.nc = col_count;
    cfg.fr = (row_factor == FAC_W'(0)) ? FAC_W'(1) : row_factor;
    cfg.fc = (col_factor == FAC_W'(0)) ? FAC_W'(1) : col_factor;
  end

  assign in_item.query    = command;
  assign in_item.raw_row  = raw_row;
  assign in_item.raw_col  = raw_col;
  assign in_item.sample   = sample;
  assign in_item.fine_row = fine_row;
  assign in_item.fine_col = fine_col;

  bgu_locate u_locate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (loc_valid),
    .out_ready (loc_ready),
    .out_loc   (loc)
  );

  bgu_store u_store (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (loc_valid),
    .in_ready  (loc_ready),
    .in_loc    (loc),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_wgt   (wgt),
    .out_data  (bank_data)
  );

  bgu_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .in_wgt    (wgt),
    .in_data   (bank_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_div   (div_in)
  );

  bgu_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_div    (div_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quotient  (quotient),
    .oor       (out_of_range)
  );

  // the blend of samples never exceeds the largest sample, so no saturation
  assign interp_value = OUT_W'(quotient);

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> interp_value == '0)
    else $error("out-of-range result carries a nonzero value");

  a_value_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> interp_value <= VALUE_MAX)
    else $error("interpolated value exceeds the largest sample");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while the output stage is empty");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule
